// ----- rtl/rllt_pkg.sv -----
// Package for the run-length line table: sizes, widths, request codes and the sequencer state type.
`default_nettype none
package rllt_pkg;

	localparam int MAX_RUNS       = 256;
	localparam int MAX_CODE_BYTES = 65536;

	localparam int LINE_W = 24;
	localparam int OFS_W  = 16;

	// Run index into the store, run count and byte count widths.
	localparam int AW    = (MAX_RUNS > 1) ? $clog2(MAX_RUNS) : 1;
	localparam int RUN_W = $clog2(MAX_RUNS + 1);
	localparam int CNT_W = $clog2(MAX_CODE_BYTES + 1);
	// A single run may cover every recorded byte, so it is as wide as the byte count.
	localparam int LEN_W = CNT_W;
	// Offsets and byte counts are compared at the wider of the two widths.
	localparam int CMP_W = (OFS_W > CNT_W) ? OFS_W : CNT_W;

	// One store entry holds a run's line above its length.
	localparam int ENT_W = LINE_W + LEN_W;

	// Request codes carried on req_type.
	typedef enum logic [0:0] {
		REQ_APPEND = 1'b0,
		REQ_LOOKUP = 1'b1
	} rllt_req_t;

	typedef enum logic [0:0] {
		ST_IDLE,
		ST_WALK
	} rllt_state_t;

endpackage
`default_nettype wire

// ----- rtl/rllt_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
`default_nettype none
module rllt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                                     clk,
	input  wire logic                                     we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                         wdata,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// ----- rtl/run_length_line_table.sv -----
// Top level of the run-length line table that maps code byte offsets to source lines.
//
// Channel   Direction  Handshake                 Payload
// command   in         start high, busy low      req_type, line_in, byte_offset
// result    out        done high for one cycle   line_out, hit, overflow
//
// An append's result appears with done in the cycle after acceptance, and the next
// command may be accepted in that same cycle. A lookup whose offset lies at or past
// the recorded byte count answers the same way. Any other lookup walks the run store
// one entry per cycle through the store's single read port: when the offset falls in
// run k (counted from 0), busy stays high until entry k has been checked, and done
// is registered from that hit.
// Reset empties the table at once: run and byte counts clear, and store entries at
// or above the run count are never used, so the store needs no clearing pass.
// The receiver cannot stall; each result is valid only in its done cycle.
`default_nettype none
module run_length_line_table (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	output logic                             busy,
	input  wire logic                        req_type,
	input  wire logic [rllt_pkg::LINE_W-1:0] line_in,
	input  wire logic [rllt_pkg::OFS_W-1:0]  byte_offset,
	output logic                             done,
	output logic      [rllt_pkg::LINE_W-1:0] line_out,
	output logic                             hit,
	output logic                             overflow
);

	rllt_pkg::rllt_state_t state_q, state_d;

	// Table bookkeeping: how many runs and bytes are recorded, and a copy of the
	// last run so an append never has to read the store.
	logic [rllt_pkg::RUN_W-1:0]  runs_q;
	logic [rllt_pkg::CNT_W-1:0]  bytes_q;
	logic [rllt_pkg::LINE_W-1:0] last_line_q;
	logic [rllt_pkg::LEN_W-1:0]  last_len_q;

	// Lookup walk state: next entry to read, running end of runs seen, target offset.
	logic [rllt_pkg::AW-1:0]     rd_addr_q;
	logic [rllt_pkg::CNT_W-1:0]  end_q;
	logic [rllt_pkg::CMP_W-1:0]  off_q;

	logic                        ram_we;
	logic [rllt_pkg::AW-1:0]     ram_waddr;
	logic [rllt_pkg::ENT_W-1:0]  ram_wdata;
	logic [rllt_pkg::ENT_W-1:0]  ram_rdata;

	logic                        accept;
	logic                        is_append;
	logic                        is_lookup;
	logic                        byte_full;
	logic                        run_full;
	logic                        same_line;
	logic                        offset_past;
	logic [rllt_pkg::CMP_W-1:0]  offset_ext;
	logic [rllt_pkg::LINE_W-1:0] rd_line;
	logic [rllt_pkg::LEN_W-1:0]  rd_len;
	logic [rllt_pkg::CNT_W-1:0]  walk_sum;
	logic                        walk_hit;

	rllt_ram #(
		.WIDTH(rllt_pkg::ENT_W),
		.DEPTH(rllt_pkg::MAX_RUNS)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(rd_addr_q),
		.rdata(ram_rdata)
	);

	// Decode of the incoming command.
	assign accept      = start && !busy;
	assign is_append   = accept && (req_type == rllt_pkg::REQ_APPEND);
	assign is_lookup   = accept && (req_type == rllt_pkg::REQ_LOOKUP);
	assign byte_full   = (bytes_q == rllt_pkg::CNT_W'(rllt_pkg::MAX_CODE_BYTES));
	assign run_full    = (runs_q == rllt_pkg::RUN_W'(rllt_pkg::MAX_RUNS));
	assign same_line   = (runs_q != '0) && (last_line_q == line_in);
	assign offset_ext  = rllt_pkg::CMP_W'(byte_offset);
	assign offset_past = (offset_ext >= rllt_pkg::CMP_W'(bytes_q));

	// The entry read last cycle arrives now; a hit ends the walk.
	assign rd_line  = ram_rdata[rllt_pkg::ENT_W-1:rllt_pkg::LEN_W];
	assign rd_len   = ram_rdata[rllt_pkg::LEN_W-1:0];
	assign walk_sum = end_q + rd_len;
	assign walk_hit = (off_q < rllt_pkg::CMP_W'(walk_sum));

	// Store write for an accepted append: either lengthen the last run in place or
	// open a new run right after it. Refused appends write nothing.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = rllt_pkg::AW'(runs_q);
		ram_wdata = {line_in, rllt_pkg::LEN_W'(1)};
		if (is_append && !byte_full) begin
			if (same_line) begin
				ram_we    = 1'b1;
				ram_waddr = rllt_pkg::AW'(runs_q - 1'b1);
				ram_wdata = {line_in, last_len_q + 1'b1};
			end else if (!run_full) begin
				ram_we = 1'b1;
			end
		end
	end

	// Next state: only a lookup that can hit starts a walk; a walk always ends on a
	// hit, since the offset is known to lie below the recorded byte count.
	always_comb begin
		state_d = state_q;
		case (state_q)
			rllt_pkg::ST_IDLE: begin
				if (is_lookup && !offset_past) begin
					state_d = rllt_pkg::ST_WALK;
				end
			end
			rllt_pkg::ST_WALK: begin
				if (walk_hit) begin
					state_d = rllt_pkg::ST_IDLE;
				end
			end
			default: state_d = rllt_pkg::ST_IDLE;
		endcase
	end

	// Outputs of the sequencer.
	always_comb begin
		case (state_q)
			rllt_pkg::ST_IDLE: busy = 1'b0;
			rllt_pkg::ST_WALK: busy = 1'b1;
			default:           busy = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= rllt_pkg::ST_IDLE;
			runs_q    <= '0;
			bytes_q   <= '0;
			rd_addr_q <= '0;
			done      <= 1'b0;
		end else begin
			state_q <= state_d;
			done    <= 1'b0;
			if (is_append) begin
				done <= 1'b1;
				if (!byte_full && (same_line || !run_full)) begin
					bytes_q <= bytes_q + 1'b1;
					if (!same_line) begin
						runs_q <= runs_q + 1'b1;
					end
				end
			end
			if (is_lookup) begin
				if (offset_past) begin
					done <= 1'b1;
				end else begin
					rd_addr_q <= rllt_pkg::AW'(1);
				end
			end
			if (state_q == rllt_pkg::ST_WALK) begin
				if (walk_hit) begin
					done      <= 1'b1;
					rd_addr_q <= '0;
				end else begin
					rd_addr_q <= rd_addr_q + 1'b1;
				end
			end
		end
	end

	// Payload registers: last run copy, walk accumulators and the result fields.
	always_ff @(posedge clk) begin
		if (is_append) begin
			line_out <= '0;
			hit      <= 1'b0;
			overflow <= 1'b1;
			if (!byte_full) begin
				if (same_line) begin
					last_len_q <= last_len_q + 1'b1;
					overflow   <= 1'b0;
				end else if (!run_full) begin
					last_line_q <= line_in;
					last_len_q  <= rllt_pkg::LEN_W'(1);
					overflow    <= 1'b0;
				end
			end
		end
		if (is_lookup) begin
			off_q    <= offset_ext;
			end_q    <= '0;
			line_out <= '0;
			hit      <= 1'b0;
			overflow <= 1'b0;
		end
		if (state_q == rllt_pkg::ST_WALK) begin
			end_q <= walk_sum;
			if (walk_hit) begin
				line_out <= rd_line;
				hit      <= 1'b1;
				overflow <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

// ----- tb/run_length_line_table_tb.sv -----
// Self-checking testbench for the run-length line table: appends, lookups and the run limit.
`default_nettype none
module run_length_line_table_tb;

	// One answer as the block presents it in its done cycle.
	typedef struct packed {
		logic [rllt_pkg::LINE_W-1:0] line;
		logic                        hit;
		logic                        overflow;
	} line_answer_t;

	logic                        clk;
	logic                        arst_n;
	logic                        start;
	logic                        busy;
	logic                        req_type;
	logic [rllt_pkg::LINE_W-1:0] line_in;
	logic [rllt_pkg::OFS_W-1:0]  byte_offset;
	logic                        done;
	logic [rllt_pkg::LINE_W-1:0] line_out;
	logic                        hit;
	logic                        overflow;

	// Shadow copy of the run table, kept in step with every accepted transaction.
	logic [rllt_pkg::LINE_W-1:0] tbl_line [rllt_pkg::MAX_RUNS];
	logic [rllt_pkg::LEN_W-1:0]  tbl_len  [rllt_pkg::MAX_RUNS];
	logic [rllt_pkg::RUN_W-1:0]  tbl_runs;
	logic [rllt_pkg::CNT_W-1:0]  tbl_bytes;

	// Answers predicted for accepted transactions, oldest first.
	line_answer_t pending_answers [$];

	int mismatches;
	int idle_pct;

	run_length_line_table dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.req_type   (req_type),
		.line_in    (line_in),
		.byte_offset(byte_offset),
		.done       (done),
		.line_out   (line_out),
		.hit        (hit),
		.overflow   (overflow)
	);

	always #4 clk = ~clk;

	// Every mismatch goes through here. Printing is capped so a broken design cannot
	// flood the log, but the count keeps going.
	task automatic report_mismatch(input string what, input int unsigned got,
			input int unsigned want);
		if (mismatches < 100)
			$display("MISMATCH at %0t: %s got %0h want %0h", $realtime, what, got, want);
		mismatches++;
	endtask

	function automatic logic [rllt_pkg::LINE_W-1:0] rand_line();
		return rllt_pkg::LINE_W'($urandom());
	endfunction

	function automatic logic [rllt_pkg::OFS_W-1:0] rand_ofs();
		return rllt_pkg::OFS_W'($urandom());
	endfunction

	// Line of the most recent run, or zero while the table is empty.
	function automatic logic [rllt_pkg::LINE_W-1:0] last_run_line();
		if (tbl_runs == '0)
			return '0;
		return tbl_line[rllt_pkg::AW'(tbl_runs - 1'b1)];
	endfunction

	// Applies one transaction to the shadow table and returns the answer it must give.
	// An append either lengthens the newest run (same line) or opens a new one; it is
	// refused once the byte total is at its limit, and a new run is also refused when
	// every run slot is in use. A lookup sums run lengths in order and stops at the
	// first run whose end lies past the offset.
	function automatic line_answer_t compute_line_answer(rllt_pkg::rllt_req_t kind,
			logic [rllt_pkg::LINE_W-1:0] line, logic [rllt_pkg::OFS_W-1:0] ofs);
		line_answer_t               ans;
		logic [rllt_pkg::CNT_W-1:0] run_end;
		logic [rllt_pkg::AW-1:0]    last;
		int                         i;
		ans = '0;
		run_end = '0;
		last = rllt_pkg::AW'(tbl_runs - 1'b1);
		if (kind == rllt_pkg::REQ_APPEND) begin
			if (int'(tbl_bytes) >= rllt_pkg::MAX_CODE_BYTES) begin
				ans.overflow = 1'b1;
			end else if (tbl_runs != '0 && tbl_line[last] == line) begin
				tbl_len[last] = tbl_len[last] + 1'b1;
				tbl_bytes = tbl_bytes + 1'b1;
			end else if (int'(tbl_runs) >= rllt_pkg::MAX_RUNS) begin
				ans.overflow = 1'b1;
			end else begin
				tbl_line[rllt_pkg::AW'(tbl_runs)] = line;
				tbl_len[rllt_pkg::AW'(tbl_runs)] = rllt_pkg::LEN_W'(1);
				tbl_runs = tbl_runs + 1'b1;
				tbl_bytes = tbl_bytes + 1'b1;
			end
		end else begin
			for (i = 0; i < int'(tbl_runs) && !ans.hit; i++) begin
				run_end = run_end + tbl_len[rllt_pkg::AW'(i)];
				if (rllt_pkg::CNT_W'(ofs) < run_end) begin
					ans.line = tbl_line[rllt_pkg::AW'(i)];
					ans.hit = 1'b1;
				end
			end
		end
		return ans;
	endfunction

	// Drives one command at the falling edge and holds it until the block takes it.
	// busy is read right after the rising edge, so it is the value the block saw at
	// that edge. start is left high afterwards so back-to-back transactions need no
	// second assignment in one time step; random idle cycles lower it.
	task automatic send_item(input rllt_pkg::rllt_req_t kind,
			input logic [rllt_pkg::LINE_W-1:0] line, input logic [rllt_pkg::OFS_W-1:0] ofs);
		@(negedge clk);
		start <= 1'b1;
		req_type <= kind;
		line_in <= line;
		byte_offset <= ofs;
		do
			@(posedge clk);
		while (busy);
		pending_answers.push_back(compute_line_answer(kind, line, ofs));
		while ($urandom_range(99) < idle_pct) begin
			@(negedge clk);
			start <= 1'b0;
		end
	endtask

	// Holds off new commands until every predicted answer has arrived. The bound covers
	// the longest walk with room to spare; anything still waiting after it is a failure.
	task automatic drain_answers();
		int waited;
		waited = 0;
		@(negedge clk);
		start <= 1'b0;
		while (pending_answers.size() != 0 && waited < rllt_pkg::MAX_RUNS * 4 + 64) begin
			@(posedge clk);
			waited++;
		end
		if (pending_answers.size() != 0) begin
			report_mismatch("answers never delivered", pending_answers.size(), 0);
			pending_answers.delete();
		end
	endtask

	// Result side: the block cannot be held off, so every done cycle is checked
	// against the oldest prediction.
	always @(posedge clk) begin
		line_answer_t want;
		if (done) begin
			if (pending_answers.size() == 0) begin
				report_mismatch("result with no transaction waiting", 32'(line_out), 0);
			end else begin
				want = pending_answers.pop_front();
				if (line_out !== want.line)
					report_mismatch("line_out", 32'(line_out), 32'(want.line));
				if (hit !== want.hit)
					report_mismatch("hit", 32'(hit), 32'(want.hit));
				if (overflow !== want.overflow)
					report_mismatch("overflow", 32'(overflow), 32'(want.overflow));
			end
		end
	end

	// An empty table misses everywhere, including offset zero and the top offset.
	task automatic test_empty_table();
		idle_pct = 0;
		send_item(rllt_pkg::REQ_LOOKUP, rand_line(), '0);
		send_item(rllt_pkg::REQ_LOOKUP, rand_line(), '1);
		drain_answers();
	endtask

	// First runs, line zero, the extreme line values, repeats that lengthen a run and
	// a line that returns after another one (which must open a fresh run). Lookups land
	// on every run, on the exact table end and far past it.
	task automatic test_directed_runs();
		int k;
		idle_pct = 0;
		send_item(rllt_pkg::REQ_APPEND, '0, rand_ofs());
		send_item(rllt_pkg::REQ_LOOKUP, '1, 16'd0);
		send_item(rllt_pkg::REQ_LOOKUP, '0, 16'd1);
		send_item(rllt_pkg::REQ_APPEND, '0, rand_ofs());
		send_item(rllt_pkg::REQ_APPEND, '1, rand_ofs());
		send_item(rllt_pkg::REQ_APPEND, '1, rand_ofs());
		send_item(rllt_pkg::REQ_APPEND, 24'd1, rand_ofs());
		send_item(rllt_pkg::REQ_APPEND, '0, rand_ofs());
		send_item(rllt_pkg::REQ_APPEND, 24'h800000, rand_ofs());
		send_item(rllt_pkg::REQ_APPEND, 24'h7FFFFF, rand_ofs());
		for (k = 0; k <= 10; k++)
			send_item(rllt_pkg::REQ_LOOKUP, rand_line(), rllt_pkg::OFS_W'(k));
		send_item(rllt_pkg::REQ_LOOKUP, '0, '1);
		send_item(rllt_pkg::REQ_LOOKUP, '1, 16'h8000);
		drain_answers();
	endtask

	// Mixed traffic. Appends mostly repeat the last line or pick from a small pool so
	// that runs both grow and open; some lines are fully random or at the extremes.
	// Lookups mostly fall inside the table, some sit at its end, some anywhere.
	// Once the run store fills, new-line appends turn into refusals.
	task automatic test_random_traffic(input int pct, input int count);
		int                          n;
		int unsigned                 pick;
		logic [rllt_pkg::LINE_W-1:0] line;
		logic [rllt_pkg::OFS_W-1:0]  ofs;
		idle_pct = pct;
		for (n = 0; n < count; n++) begin
			pick = $urandom_range(99);
			if ($urandom_range(99) < 55) begin
				if (pick < 40)
					line = last_run_line();
				else if (pick < 70)
					line = rllt_pkg::LINE_W'($urandom_range(7));
				else if (pick < 90)
					line = rand_line();
				else
					line = pick[0] ? '1 : '0;
				send_item(rllt_pkg::REQ_APPEND, line, rand_ofs());
			end else begin
				if (pick < 70 && tbl_bytes != '0)
					ofs = rllt_pkg::OFS_W'($urandom_range(int'(tbl_bytes) - 1));
				else if (pick < 85)
					ofs = rllt_pkg::OFS_W'(int'(tbl_bytes) + int'($urandom_range(3)));
				else
					ofs = rand_ofs();
				send_item(rllt_pkg::REQ_LOOKUP, rand_line(), ofs);
			end
			// Now and then the sender waits for the pipeline to empty completely.
			if ($urandom_range(39) == 0)
				drain_answers();
		end
		drain_answers();
	endtask

	// Fills every run slot, then checks that a new line is refused while a repeat of
	// the last line still lengthens the last run. The two lookups inside the last run
	// walk the whole store; the third sits at the table end.
	task automatic test_run_store_full();
		idle_pct = 0;
		while (int'(tbl_runs) < rllt_pkg::MAX_RUNS)
			send_item(rllt_pkg::REQ_APPEND, last_run_line() + 1'b1, rand_ofs());
		send_item(rllt_pkg::REQ_APPEND, ~last_run_line(), rand_ofs());
		send_item(rllt_pkg::REQ_APPEND, last_run_line(), rand_ofs());
		send_item(rllt_pkg::REQ_APPEND, last_run_line() ^ 24'h000001, rand_ofs());
		send_item(rllt_pkg::REQ_LOOKUP, '0, rllt_pkg::OFS_W'(int'(tbl_bytes) - 1));
		send_item(rllt_pkg::REQ_LOOKUP, '0, rllt_pkg::OFS_W'(int'(tbl_bytes) - 2));
		send_item(rllt_pkg::REQ_LOOKUP, '0, rllt_pkg::OFS_W'(tbl_bytes));
		drain_answers();
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		req_type = rllt_pkg::REQ_APPEND;
		line_in = '0;
		byte_offset = '0;
		tbl_runs = '0;
		tbl_bytes = '0;
		mismatches = 0;
		idle_pct = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_empty_table();
		test_directed_runs();
		// Sender idles lightly, then heavily, then not at all.
		test_random_traffic(17, 430);
		test_random_traffic(51, 430);
		test_random_traffic(0, 440);
		test_run_store_full();

		// Let any late or spurious result show up before the verdict.
		repeat (rllt_pkg::MAX_RUNS + 4) @(posedge clk);
		if (mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	// Watchdog: several times the slowest correct run, with every lookup walking the
	// whole store.
	initial begin
		#20_000_000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule
`default_nettype wire
